### rtl/assert_macros.svh
// assertion macros used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// implication in the same cycle
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// implication into the following cycle
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define AST_SAME(label, clk, rst_n, ante, cons)
`define AST_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/nstp_pkg.sv
// types, codes and note table for the tone player
`default_nettype none
package nstp_pkg;

    // input word kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_PLAY  = 3'd2;
    localparam logic [2:0] KIND_STOP  = 3'd3;
    localparam logic [2:0] KIND_BEEP  = 3'd4;

    localparam logic [7:0] GAP_RESET = 8'd25;
    localparam logic [7:0] NOTE_MAX  = 8'd131;
    localparam logic [7:0] SEMITONES = 8'd12;
    localparam logic [3:0] TOP_OCT   = 4'd10;
    // reciprocal of twelve, scaled by 2^11, exact for notes up to 131
    localparam logic [15:0] RECIP_12 = 16'd171;

    // top octave frequencies in hertz
    localparam logic [13:0] NOTE_HZ [0:11] = '{
        14'd8372, 14'd8870, 14'd9397, 14'd9956, 14'd10548, 14'd11175,
        14'd11840, 14'd12544, 14'd13290, 14'd14080, 14'd14917, 14'd15804
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  elapsed_ms;
        logic [7:0]  note_number;
        logic [15:0] note_len_ms;
        logic [5:0]  entry_index;
        logic [6:0]  note_count;
    } t_in;

    typedef struct packed {
        logic        tone_on;
        logic [13:0] tone_hz;
        logic        beep_done;
        logic        play_done;
        logic        playing;
    } t_out;

    typedef struct packed {
        logic [7:0]  note;
        logic [15:0] dur;
    } t_entry;

    // sequencer commands to the datapath
    typedef struct packed {
        logic latch;
        logic act;
        logic load;
        logic fin;
    } t_cmd;

    // datapath status to the sequencer
    typedef struct packed {
        logic play_go;
        logic next_go;
    } t_sts;

    // note number to tone frequency
    function automatic logic [13:0] note_hz(input logic [7:0] note);
        logic [7:0]  n;
        logic [15:0] prod;
        logic [3:0]  oct;
        logic [7:0]  semi_w;
        logic [3:0]  semi;
        logic [3:0]  sh;
        n      = (note > NOTE_MAX) ? NOTE_MAX : note;
        prod   = 16'(n) * RECIP_12;
        oct    = prod[14:11];
        semi_w = n - 8'(8'({4'b0, oct}) * SEMITONES);
        semi   = semi_w[3:0];
        sh     = TOP_OCT - oct;
        return NOTE_HZ[semi] >> sh;
    endfunction

endpackage
`default_nettype wire

### rtl/note_sequence_tone_player_core.sv
// Each word is taken when start is high and busy low; its result word shows on o_result
// with o_valid for one cycle in state OUT, after ACT, RD, FIN and NXT, RD and NXT only
// when needed; busy drops the cycle after, so a word is taken only once the last is out.
// RD and NXT serve the note store's registered read port, for a play word and for a note
// that follows an ended one. Synchronous active-low reset clears the player state, sets
// gap_ms to 25 and leaves the note store uncleared: entries keep old contents until written.
`default_nettype none
`include "assert_macros.svh"
module note_sequence_tone_player_core #(
    parameter int NOTE_SLOTS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire nstp_pkg::t_in i_item,
    output logic               o_valid,
    output nstp_pkg::t_out     o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata
);

    nstp_pkg::t_cmd cmd;
    nstp_pkg::t_sts sts;

    // sequencer
    nstp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // datapath
    nstp_dp #(
        .NOTE_SLOTS (NOTE_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (sts),
        .o_result    (o_result)
    );

    // checks
    `AST_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `AST_NEXT(a_valid_idle, i_clk, i_rst_n, o_valid, !busy && !o_valid)
    `AST_SAME(a_play_beep, i_clk, i_rst_n, o_result.play_done, o_result.beep_done)
    `AST_SAME(a_play_stop, i_clk, i_rst_n, o_result.play_done, !o_result.playing)

endmodule
`default_nettype wire

### rtl/nstp_ctrl.sv
// sequencer state machine for the tone player
`default_nettype none
module nstp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire nstp_pkg::t_sts i_sts,
    output nstp_pkg::t_cmd     o_cmd,
    output logic               busy,
    output logic               o_valid
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACT  = 6'b000010,
        S_RD   = 6'b000100,
        S_FIN  = 6'b001000,
        S_NXT  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ACT;
                end
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = i_sts.play_go ? S_RD : S_FIN;
            end
            S_RD: begin
                o_cmd.load = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = i_sts.next_go ? S_NXT : S_OUT;
            end
            S_NXT: begin
                o_cmd.load = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule
`default_nettype wire

### rtl/nstp_dp.sv
// datapath: note store, timing state and tone registers
`default_nettype none
module nstp_dp #(
    parameter int NOTE_SLOTS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire nstp_pkg::t_cmd i_cmd,
    input  wire nstp_pkg::t_in  i_item,
    input  wire logic           i_cfg_we,
    input  wire logic [7:0]     i_cfg_wdata,
    output nstp_pkg::t_sts      o_sts,
    output nstp_pkg::t_out      o_result
);

    localparam int AW = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
    localparam logic [6:0] SLOTS_SAT = (NOTE_SLOTS > 127) ? 7'd127 : 7'(NOTE_SLOTS);

    nstp_pkg::t_entry r_mem [0:NOTE_SLOTS-1];
    nstp_pkg::t_entry r_rd_data;
    nstp_pkg::t_in    r_item;

    logic [7:0]  r_gap;
    logic [15:0] r_rem,    n_rem;
    logic        r_end,    n_end;
    logic        r_sound,  n_sound;
    logic [13:0] r_hz,     n_hz;
    logic        r_active, n_active;
    logic [6:0]  r_len,    n_len;
    logic [6:0]  r_pos,    n_pos;
    logic        r_beep,   n_beep;
    logic        r_play,   n_play;

    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [6:0]    sat_len;

    // play count limited to the store depth
    assign sat_len = (32'(r_item.note_count) > NOTE_SLOTS) ? SLOTS_SAT : r_item.note_count;

    assign mem_we = i_cmd.act && (r_item.kind == nstp_pkg::KIND_WRITE)
                    && (32'(r_item.entry_index) < NOTE_SLOTS);

    // status for the sequencer
    assign o_sts.play_go = (r_item.kind == nstp_pkg::KIND_PLAY) && (sat_len != 7'd0);
    assign o_sts.next_go = r_end && (r_pos < r_len);

    // per-phase update of the player state
    always_comb begin
        n_rem    = r_rem;
        n_end    = r_end;
        n_sound  = r_sound;
        n_hz     = r_hz;
        n_active = r_active;
        n_len    = r_len;
        n_pos    = r_pos;
        n_beep   = r_beep;
        n_play   = r_play;
        rd_addr  = '0;
        if (i_cmd.act) begin
            n_beep = 1'b0;
            n_play = 1'b0;
            case (r_item.kind)
                nstp_pkg::KIND_TICK: begin
                    if (r_rem > {8'd0, r_item.elapsed_ms}) begin
                        n_rem = r_rem - {8'd0, r_item.elapsed_ms};
                        if (n_rem < {8'd0, r_gap}) begin
                            n_sound = 1'b0;
                        end
                    end else if (r_rem != 16'd0) begin
                        n_rem = 16'd0;
                        n_end = 1'b1;
                    end
                end
                nstp_pkg::KIND_PLAY: begin
                    n_len = sat_len;
                    n_pos = 7'd0;
                    if (sat_len != 7'd0) begin
                        n_active = 1'b1;
                        n_pos    = 7'd1;
                    end
                end
                nstp_pkg::KIND_STOP: begin
                    n_len    = 7'd0;
                    n_pos    = 7'd0;
                    n_active = 1'b0;
                end
                nstp_pkg::KIND_BEEP: begin
                    n_hz    = nstp_pkg::note_hz(r_item.note_number);
                    n_end   = r_end || (r_rem != 16'd0);
                    n_rem   = r_item.note_len_ms;
                    n_sound = 1'b1;
                end
                default: begin
                end
            endcase
        end
        // start a note from the stored entry
        if (i_cmd.load) begin
            n_hz    = nstp_pkg::note_hz(r_rd_data.note);
            n_end   = r_end || (r_rem != 16'd0);
            n_rem   = r_rd_data.dur;
            n_sound = 1'b1;
        end
        // end of note handling
        if (i_cmd.fin && r_end) begin
            n_end   = 1'b0;
            n_sound = 1'b0;
            n_beep  = 1'b1;
            if (r_pos < r_len) begin
                rd_addr = AW'(r_pos);
                n_pos   = r_pos + 7'd1;
            end else if (r_pos != 7'd0) begin
                n_active = 1'b0;
                n_play   = 1'b1;
            end
        end
    end

    // note store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(r_item.entry_index)] <= '{note: r_item.note_number,
                                                dur: r_item.note_len_ms};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // captured input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
    end

    // player state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= nstp_pkg::GAP_RESET;
            r_rem    <= '0;
            r_end    <= 1'b0;
            r_sound  <= 1'b0;
            r_hz     <= '0;
            r_active <= 1'b0;
            r_len    <= '0;
            r_pos    <= '0;
            r_beep   <= 1'b0;
            r_play   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap <= i_cfg_wdata;
            end
            r_rem    <= n_rem;
            r_end    <= n_end;
            r_sound  <= n_sound;
            r_hz     <= n_hz;
            r_active <= n_active;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_beep   <= n_beep;
            r_play   <= n_play;
        end
    end

    // result word
    assign o_result.tone_on   = r_sound;
    assign o_result.tone_hz   = r_hz;
    assign o_result.beep_done = r_beep;
    assign o_result.play_done = r_play;
    assign o_result.playing   = r_active;

endmodule
`default_nettype wire

### test/tone_check_pkg.sv
// tone player predictor and result scoreboard for the testbench
package tone_check_pkg;
    import nstp_pkg::*;

    localparam int SLOTS = 64;

    // top octave tone frequencies in hertz, semitone 0 to 11
    localparam int TOP_HZ [12] = '{
        8372, 8870, 9397, 9956, 10548, 11175,
        11840, 12544, 13290, 14080, 14917, 15804
    };

    class tone_scoreboard;
        logic [7:0]  gap;
        logic [15:0] left_ms;
        bit          end_due;
        bit          sounding;
        bit          active;
        logic [13:0] hz;
        t_entry      notes [SLOTS];
        logic [6:0]  seq_len;
        logic [6:0]  seq_pos;
        t_out        waiting [$];
        int          errors;
        int          results_seen;

        function new();
            gap          = GAP_RESET;
            left_ms      = '0;
            end_due      = 1'b0;
            sounding     = 1'b0;
            active       = 1'b0;
            hz           = '0;
            seq_len      = '0;
            seq_pos      = '0;
            errors       = 0;
            results_seen = 0;
            foreach (notes[i]) notes[i] = '0;
        endfunction

        // note number to frequency, saturating at the top note
        function logic [13:0] tone_of(logic [7:0] note);
            int n;
            n = (note > NOTE_MAX) ? int'(NOTE_MAX) : int'(note);
            return 14'(TOP_HZ[n % 12] >> (10 - n / 12));
        endfunction

        // a new note cuts short any note that still has time left
        function void sound_note(logic [7:0] note, logic [15:0] dur);
            hz = tone_of(note);
            if (left_ms != 0) end_due = 1'b1;
            left_ms  = dur;
            sounding = 1'b1;
        endfunction

        // predict the result word of one accepted input word
        function void note_word(t_in w);
            bit          beep_end;
            bit          seq_end;
            logic [6:0]  at;
            t_out        res;
            beep_end = 1'b0;
            seq_end  = 1'b0;
            case (w.kind)
                KIND_TICK: begin
                    if (left_ms > 16'(w.elapsed_ms)) begin
                        left_ms = left_ms - 16'(w.elapsed_ms);
                        if (left_ms < 16'(gap)) sounding = 1'b0;
                    end else if (left_ms != 0) begin
                        left_ms = '0;
                        end_due = 1'b1;
                    end
                end
                KIND_WRITE: begin
                    notes[w.entry_index].note = w.note_number;
                    notes[w.entry_index].dur  = w.note_len_ms;
                end
                KIND_PLAY: begin
                    seq_len = (w.note_count > SLOTS) ? 7'(SLOTS) : w.note_count;
                    seq_pos = '0;
                    if (seq_len != 0) begin
                        active = 1'b1;
                        sound_note(notes[0].note, notes[0].dur);
                        seq_pos = 7'd1;
                    end
                end
                KIND_STOP: begin
                    seq_len = '0;
                    seq_pos = '0;
                    active  = 1'b0;
                end
                KIND_BEEP: sound_note(w.note_number, w.note_len_ms);
                default: ;
            endcase
            // at most one pending end is handled per word
            if (end_due) begin
                end_due  = 1'b0;
                sounding = 1'b0;
                beep_end = 1'b1;
                if (seq_pos < seq_len) begin
                    at      = seq_pos;
                    seq_pos = at + 7'd1;
                    sound_note(notes[at[5:0]].note, notes[at[5:0]].dur);
                end else if (seq_pos != 0) begin
                    active  = 1'b0;
                    seq_end = 1'b1;
                end
            end
            res.tone_on   = sounding;
            res.tone_hz   = hz;
            res.beep_done = beep_end;
            res.play_done = seq_end;
            res.playing   = active;
            waiting.push_back(res);
        endfunction

        // one line per mismatch
        task report_mismatch(string what);
            $display("mismatch at result %0d: %s", results_seen, what);
            errors++;
        endtask

        task compare_field(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
        endtask

        // compare a result word with the oldest prediction
        task check_result(t_out got);
            t_out want;
            results_seen++;
            if (waiting.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = waiting.pop_front();
                compare_field("tone_on", 16'(got.tone_on), 16'(want.tone_on));
                compare_field("tone_hz", 16'(got.tone_hz), 16'(want.tone_hz));
                compare_field("beep_done", 16'(got.beep_done), 16'(want.beep_done));
                compare_field("play_done", 16'(got.play_done), 16'(want.play_done));
                compare_field("playing", 16'(got.playing), 16'(want.playing));
            end
        endtask
    endclass

endpackage

### test/tb_top.sv
// top of the tone player testbench: clock, reset, word driver, checker and watchdog
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nstp_pkg::*;
    import tone_check_pkg::*;

    localparam int ITEMS       = 1350;
    localparam int PHASES      = 4;
    localparam int QUIET_LIMIT = 400;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    t_in        i_item      = '0;
    logic       busy;
    logic       o_valid;
    t_out       o_result;

    tone_scoreboard tones;
    bit             written [SLOTS];
    int             filled;
    int             sent;
    bit             idle_on;
    int             quiet_cycles = 0;

    note_sequence_tone_player_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // every result word is checked at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) tones.check_result(o_result);
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // offer one word, hold it until taken, then maybe idle for a short burst
    task automatic send_word(input t_in w);
        i_item <= w;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        tones.note_word(w);
        sent++;
        if (w.kind == KIND_WRITE) begin
            written[w.entry_index] = 1'b1;
            while (filled < SLOTS && written[filled]) filled++;
        end
        if (idle_on && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // hold off until every predicted word has come back, then let busy settle
    task automatic drain();
        start <= 1'b0;
        while (tones.waiting.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_gap(input logic [7:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tones.gap = value;
    endtask

    function automatic t_in word_of(logic [2:0] kind, logic [7:0] elapsed, logic [7:0] note,
                                    logic [15:0] dur, logic [5:0] slot, logic [6:0] count);
        t_in w;
        w.kind        = kind;
        w.elapsed_ms  = elapsed;
        w.note_number = note;
        w.note_len_ms = dur;
        w.entry_index = slot;
        w.note_count  = count;
        return w;
    endfunction

    // mostly short notes, a few endless or very long ones
    function automatic logic [15:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 16'd0;
        if (r < 8) return 16'($urandom);
        return 16'($urandom_range(1, 400));
    endfunction

    // favour the first unwritten slot so the written run grows
    function automatic logic [5:0] pick_slot();
        if (filled < SLOTS && $urandom_range(0, 3) != 0) return 6'(filled);
        return 6'($urandom);
    endfunction

    // play counts stay within the written run of slots, any count once every slot is written
    function automatic logic [6:0] pick_count();
        if (filled == SLOTS) return 7'($urandom);
        return 7'($urandom_range(0, filled));
    endfunction

    function automatic t_in make_word();
        t_in w;
        int  r;
        w = word_of(KIND_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 6'($urandom),
                    7'($urandom));
        r = $urandom_range(0, 99);
        if (r < 45) begin
            if ($urandom_range(0, 3) == 0) w.elapsed_ms = 8'($urandom_range(0, 40));
        end else if (r < 62) begin
            w.kind        = KIND_WRITE;
            w.entry_index = pick_slot();
            w.note_len_ms = pick_duration();
        end else if (r < 70) begin
            w.kind       = KIND_PLAY;
            w.note_count = pick_count();
        end else if (r < 76) begin
            w.kind = KIND_STOP;
        end else if (r < 95) begin
            w.kind        = KIND_BEEP;
            w.note_len_ms = pick_duration();
        end else begin
            // unused kinds
            w.kind = KIND_BEEP + 3'($urandom_range(1, 3));
        end
        return w;
    endfunction

    // a few note writes, a play, then mostly ticks until the sequence ends or the word budget runs out
    task automatic run_sequence();
        t_in w;
        int  span;
        int  budget;
        repeat ($urandom_range(1, 4)) begin
            w             = make_word();
            w.kind        = KIND_WRITE;
            w.entry_index = pick_slot();
            w.note_len_ms = pick_duration();
            send_word(w);
        end
        w      = make_word();
        w.kind = KIND_PLAY;
        span   = (filled < 8) ? filled : 8;
        case ($urandom_range(0, 9))
            0: w.note_count = 7'($urandom_range(1, filled));
            1: w.note_count = (filled == SLOTS) ? 7'($urandom_range(SLOTS, 127)) : 7'(filled);
            default: w.note_count = 7'($urandom_range(1, span));
        endcase
        budget = (w.note_count > 16) ? 200 : 40;
        send_word(w);
        while (tones.active && budget > 0) begin
            w = make_word();
            if ($urandom_range(0, 9) != 0) begin
                w.kind       = KIND_TICK;
                w.elapsed_ms = 8'($urandom_range(1, 255));
            end
            send_word(w);
            budget--;
        end
    endtask

    initial begin
        t_in        w;
        int         target;
        int         step;
        logic [7:0] gaps [PHASES];
        tones   = new();
        filled  = 0;
        sent    = 0;
        idle_on = 1'b1;
        gaps    = '{8'd0, 8'd255, 8'($urandom), GAP_RESET};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, mute threshold still at its reset value
        send_word(word_of(KIND_TICK, 8'd0, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_BEEP, 8'd0, 8'd0, 16'd100, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd80, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_BEEP, 8'd0, 8'd131, 16'hffff, 6'd0, 7'd0));
        // beep over a sounding note, then the chained end on the next tick
        send_word(word_of(KIND_BEEP, 8'd0, 8'd255, 16'd10, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_WRITE, 8'd0, 8'd12, 16'd30, 6'd0, 7'd0));
        send_word(word_of(KIND_WRITE, 8'd0, 8'd59, 16'd40, 6'd1, 7'd0));
        send_word(word_of(KIND_WRITE, 8'd0, 8'd200, 16'd1, 6'd2, 7'd0));
        send_word(word_of(KIND_WRITE, 8'd0, 8'd255, 16'hffff, 6'd63, 7'd0));
        send_word(word_of(KIND_PLAY, 8'd0, 8'd0, 16'd0, 6'd0, 7'd3));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_BEEP, 8'd0, 8'd100, 16'd50, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        // finished sequence left in place reports the end again
        send_word(word_of(KIND_BEEP, 8'd0, 8'd72, 16'd5, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        // stop keeps the sounding note's time
        send_word(word_of(KIND_PLAY, 8'd0, 8'd0, 16'd0, 6'd0, 7'd1));
        send_word(word_of(KIND_STOP, 8'd0, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd10, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_TICK, 8'd255, 8'd0, 16'd0, 6'd0, 7'd0));
        send_word(word_of(KIND_PLAY, 8'd0, 8'd0, 16'd0, 6'd0, 7'd0));
        for (int k = 1; k <= 3; k++) begin
            w      = make_word();
            w.kind = KIND_BEEP + 3'(k);
            send_word(w);
        end

        // fill the whole store, then play past its end
        for (int s = 0; s < SLOTS; s++) begin
            w             = make_word();
            w.kind        = KIND_WRITE;
            w.entry_index = 6'(s);
            w.note_len_ms = pick_duration();
            send_word(w);
        end
        w            = make_word();
        w.kind       = KIND_PLAY;
        w.note_count = 7'($urandom_range(SLOTS, 127));
        send_word(w);

        // random phases, one mute threshold each, no idling in the last
        target = sent;
        step   = (ITEMS - sent) / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            set_gap(gaps[p]);
            target += step;
            while (sent < target) begin
                if ($urandom_range(0, 19) == 0) drain();
                idle_on = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 3) != 0) begin
                    run_sequence();
                end else begin
                    repeat ($urandom_range(5, 20)) send_word(make_word());
                end
            end
        end

        drain();
        if (tones.errors == 0 && tones.waiting.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### note_sequence_tone_player_core.f
+incdir+rtl
rtl/nstp_pkg.sv
rtl/nstp_ctrl.sv
rtl/nstp_dp.sv
rtl/note_sequence_tone_player_core.sv
test/tone_check_pkg.sv
test/tb_top.sv
